>>> rtl/esrs_pkg.sv
package esrs_pkg;

   localparam int MaxSectionsDefault = 16;
   localparam int PosW   = 32;
   localparam int FacW   = 16;
   localparam int CountW = 5;
   localparam int IdxW   = 4;

   localparam logic ReqLoad  = 1'b0;
   localparam logic ReqQuery = 1'b1;

   typedef struct packed {
      logic clear_acc;
      logic scan_step;
      logic load_sel;
      logic div_start;
      logic sqrt_start;
      logic mul_step;
      logic [3:0] op;
      logic latch_out;
   } ctl_type;

   typedef struct packed {
      logic scan_done;
      logic hit;
      logic unit_done;
      logic mul_done;
   } sts_type;

   localparam logic [3:0] OpW    = 4'd0;
   localparam logic [3:0] OpH    = 4'd1;
   localparam logic [3:0] OpF    = 4'd2;
   localparam logic [3:0] OpR    = 4'd3;
   localparam logic [3:0] OpS    = 4'd4;
   localparam logic [3:0] OpC    = 4'd5;
   localparam logic [3:0] OpG    = 4'd6;
   localparam logic [3:0] OpD    = 4'd7;

endpackage

>>> rtl/elliptic_section_radial_scale_core.sv
// Section table lookup and radial scale unit. Load items (req_type 0) write one table slot and
// give no result; query items (req_type 1) give one result. A query whose point misses every
// interval gives its result after the table scan; a hit goes through a scan of one table
// entry per cycle through the registered read port, a 64-step restoring divide for the
// interval weight, a 32-step square root, two more 64-step divides for the ratios on the same
// divider, and twelve multiply steps on one shared multiplier. A point on the axis skips the
// two ratio divides. Only one item is in work at a time; the next is taken once the result
// register is free.
module elliptic_section_radial_scale_core #(
   parameter int MaxSections = esrs_pkg::MaxSectionsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [4:0]         csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [3:0]         req_entry_index,
   input  logic signed [31:0] req_section_position,
   input  logic signed [15:0] req_factor_upper_y,
   input  logic signed [15:0] req_factor_z,
   input  logic signed [15:0] req_factor_lower_y,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_delta_y,
   output logic signed [31:0] rsp_delta_z,
   output logic               rsp_in_range,
   output logic [3:0]         rsp_interval_found
);
   import esrs_pkg::*;

   logic [4:0]  count_ff;
   logic        load_we, pt_we;
   logic [31:0] r_probe;
   ctl_type     ctl;
   sts_type     sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   esrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .load_we   (load_we),
      .pt_we     (pt_we),
      .r_value   (r_probe),
      .ctl       (ctl),
      .sts       (sts)
   );

   esrs_datapath #(.MaxSections(MaxSections)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .sts              (sts),
      .load_we          (load_we),
      .entry_index      (req_entry_index),
      .section_position (req_section_position),
      .factor_upper_y   (req_factor_upper_y),
      .factor_z         (req_factor_z),
      .factor_lower_y   (req_factor_lower_y),
      .pt_we            (pt_we),
      .point_x          (req_point_x),
      .point_y          (req_point_y),
      .point_z          (req_point_z),
      .count            (count_ff),
      .delta_y          (rsp_delta_y),
      .delta_z          (rsp_delta_z),
      .in_range         (rsp_in_range),
      .interval_found   (rsp_interval_found),
      .r_out            (r_probe)
   );
endmodule

>>> rtl/esrs_divider.sv
module esrs_divider (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  dividend,
   input  logic [63:0]  divisor,
   output logic [63:0]  quotient,
   output logic         done
);
   logic [63:0] quo_ff, quo_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] dvs_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = busy_ff && (cnt_ff == 7'd1);
      trial   = {rem_ff[63:0], quo_ff[63]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[62:0], 1'b0};
         rem_in = trial;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in    = trial - {1'b0, dvs_ff};
            quo_in[0] = 1'b1;
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

>>> rtl/esrs_sqrt.sv
module esrs_sqrt (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  radicand,
   output logic [31:0]  root,
   output logic         done
);
   logic [63:0] val_ff, val_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   always_comb begin
      val_in  = val_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = busy_ff && bit_ff[0];
      if (start) begin
         val_in  = radicand;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (val_ff >= res_ff + bit_ff) begin
            val_in = val_ff - (res_ff + bit_ff);
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      val_ff <= val_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign root = res_ff[31:0];
   assign done = done_ff;
endmodule

>>> rtl/esrs_datapath.sv
module esrs_datapath #(
   parameter int MaxSections = esrs_pkg::MaxSectionsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  esrs_pkg::ctl_type     ctl,
   output esrs_pkg::sts_type     sts,
   input  logic                  load_we,
   input  logic [3:0]            entry_index,
   input  logic signed [31:0]    section_position,
   input  logic signed [15:0]    factor_upper_y,
   input  logic signed [15:0]    factor_z,
   input  logic signed [15:0]    factor_lower_y,
   input  logic                  pt_we,
   input  logic signed [31:0]    point_x,
   input  logic signed [31:0]    point_y,
   input  logic signed [31:0]    point_z,
   input  logic [4:0]            count,
   output logic signed [31:0]    delta_y,
   output logic signed [31:0]    delta_z,
   output logic                  in_range,
   output logic [3:0]            interval_found,
   output logic [31:0]           r_out
);
   import esrs_pkg::*;
   localparam int AW = (MaxSections > 1) ? $clog2(MaxSections) : 1;
   localparam int CW = AW + 1;

   logic signed [31:0] pos_mem [MaxSections];
   logic [47:0]        fac_mem [MaxSections];
   logic signed [31:0] pos_rd;
   logic [47:0]        fac_rd;
   logic [AW-1:0]      rd_addr;

   logic [CW-1:0]      scan_ff, scan_in;
   logic [CW-1:0]      n_eff;
   logic               hit_ff;
   logic [AW-1:0]      found_ff;
   logic signed [31:0] prev_pos_ff, xlo_ff, xhi_ff;
   logic [47:0]        prev_fac_ff, flo_ff, fhi_ff;
   logic               first_ff;
   logic               rd_valid_ff;

   logic signed [31:0] x_ff, y_ff, z_ff;
   logic [31:0]        ay, az;

   logic               div_start, div_done, sq_done;
   logic [63:0]        div_a, div_b, div_q;
   logic [31:0]        sq_root;

   logic [16:0]        w_ff, h_ff, s_ff, c_ff;
   logic signed [47:0] fy_ff, fz_ff;
   logic signed [47:0] gy_ff, gz_ff;
   logic [31:0]        r_ff;
   logic signed [31:0] dy_ff, dz_ff;
   logic               inr_ff;
   logic [3:0]         ifound_ff;

   logic [1:0]         mph_ff;
   logic signed [95:0] acc_ff;
   logic signed [63:0] prod;
   logic               mul_last;

   assign n_eff = (int'(count) > MaxSections) ? CW'(MaxSections) : CW'(count);
   assign ay = y_ff[31] ? 32'(-y_ff) : 32'(y_ff);
   assign az = z_ff[31] ? 32'(-z_ff) : 32'(z_ff);
   assign rd_addr = scan_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (load_we && (int'(entry_index) < MaxSections)) begin
         pos_mem[AW'(entry_index)] <= section_position;
         fac_mem[AW'(entry_index)] <= {factor_lower_y, factor_z, factor_upper_y};
      end
      pos_rd <= pos_mem[rd_addr];
      fac_rd <= fac_mem[rd_addr];
   end

   always_comb begin
      scan_in = scan_ff;
      if (ctl.clear_acc) begin
         scan_in = '0;
      end else if (ctl.scan_step && (scan_ff < n_eff)) begin
         scan_in = scan_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff     <= '0;
         hit_ff      <= 1'b0;
         rd_valid_ff <= 1'b0;
         first_ff    <= 1'b1;
      end else begin
         scan_ff     <= scan_in;
         rd_valid_ff <= ctl.scan_step && (scan_ff < n_eff);
         if (ctl.clear_acc) begin
            hit_ff   <= 1'b0;
            first_ff <= 1'b1;
         end else if (rd_valid_ff) begin
            first_ff <= 1'b0;
            if (!first_ff && (x_ff >= prev_pos_ff) && (x_ff < pos_rd)) begin
               hit_ff <= 1'b1;
            end
         end
      end
      if (pt_we) begin
         x_ff <= point_x;
         y_ff <= point_y;
         z_ff <= point_z;
      end
      if (rd_valid_ff) begin
         prev_pos_ff <= pos_rd;
         prev_fac_ff <= fac_rd;
         if (!first_ff && (x_ff >= prev_pos_ff) && (x_ff < pos_rd)) begin
            found_ff <= AW'(scan_ff - CW'(2));
            xlo_ff   <= prev_pos_ff;
            xhi_ff   <= pos_rd;
            flo_ff   <= prev_fac_ff;
            fhi_ff   <= fac_rd;
         end
      end
   end

   assign sts.scan_done = ctl.scan_step && (scan_ff >= n_eff) && !rd_valid_ff;
   assign sts.hit       = hit_ff;

   // divider: op selects w, s or c
   always_comb begin
      div_a = '0;
      div_b = 64'd1;
      unique case (ctl.op)
         OpW: begin
            div_a = {16'd0, 32'(x_ff - xlo_ff), 16'd0};
            div_b = {32'd0, 32'(xhi_ff - xlo_ff)};
         end
         OpS: begin
            div_a = {16'd0, ay, 16'd0};
            div_b = {32'd0, r_ff};
         end
         OpC: begin
            div_a = {16'd0, az, 16'd0};
            div_b = {32'd0, r_ff};
         end
         default: begin
            div_a = '0;
            div_b = 64'd1;
         end
      endcase
   end
   assign div_start = ctl.div_start;

   esrs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .quotient (div_q),
      .done     (div_done)
   );

   esrs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.sqrt_start),
      .radicand (64'(ay) * 64'(ay) + 64'(az) * 64'(az)),
      .root     (sq_root),
      .done     (sq_done)
   );

   assign sts.unit_done = div_done || sq_done;
   assign r_out         = sq_root;

   // shared multiplier sequence, one product per cycle
   logic signed [15:0] fy_lo, fy_hi, fz_lo, fz_hi;
   logic signed [33:0] mul_a;
   logic signed [33:0] mul_b;

   always_comb begin
      fy_lo = y_ff[31] ? flo_ff[47:32] : flo_ff[15:0];
      fy_hi = y_ff[31] ? fhi_ff[47:32] : fhi_ff[15:0];
      fz_lo = flo_ff[31:16];
      fz_hi = fhi_ff[31:16];
      mul_a = '0;
      mul_b = '0;
      unique case (ctl.op)
         OpH: begin
            mul_a = 34'(w_ff);
            mul_b = (mph_ff == 2'd0) ? 34'(w_ff) : 34'(acc_ff[31:0]);
         end
         OpF: begin
            unique case (mph_ff)
               2'd0: begin mul_a = 34'(fy_lo); mul_b = 34'(17'd65536 - h_ff); end
               2'd1: begin mul_a = 34'(fy_hi); mul_b = 34'(h_ff); end
               2'd2: begin mul_a = 34'(fz_lo); mul_b = 34'(17'd65536 - h_ff); end
               default: begin mul_a = 34'(fz_hi); mul_b = 34'(h_ff); end
            endcase
         end
         OpG: begin
            unique case (mph_ff)
               2'd0: begin mul_a = 34'(fy_ff); mul_b = 34'(s_ff); end
               2'd1: begin mul_a = 34'(fz_ff); mul_b = 34'(17'd65536 - s_ff); end
               2'd2: begin mul_a = 34'(fz_ff); mul_b = 34'(c_ff); end
               default: begin mul_a = 34'(fy_ff); mul_b = 34'(17'd65536 - c_ff); end
            endcase
         end
         OpD: begin
            mul_a = (mph_ff == 2'd0) ? 34'(y_ff) : 34'(z_ff);
            mul_b = (mph_ff == 2'd0) ? 34'(gy_ff) : 34'(gz_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // fy/fz fit in 34 bits, g terms fit in 30 bits: products in 64 bits
   assign prod = 64'(mul_a) * 64'(mul_b);

   assign mul_last = ctl.mul_step &&
                     ((((ctl.op == OpH) || (ctl.op == OpD)) && (mph_ff == 2'd1)) ||
                      (mph_ff == 2'd3));

   function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
      logic signed [95:0] t;
      begin
         t = v >>> 24;
         if (t > 96'sd2147483647) begin
            sat32 = 32'sh7fff_ffff;
         end else if (t < -96'sd2147483648) begin
            sat32 = 32'sh8000_0000;
         end else begin
            sat32 = t[31:0];
         end
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mph_ff <= '0;
      end else if (ctl.clear_acc || !ctl.mul_step || mul_last) begin
         mph_ff <= '0;
      end else begin
         mph_ff <= mph_ff + 2'd1;
      end
      if (ctl.mul_step) begin
         unique case (ctl.op)
            OpH: begin
               if (mph_ff == 2'd0) begin
                  acc_ff <= 96'(prod);
               end else begin
                  h_ff <= 17'(((96'(3) * (acc_ff << 16)) - 96'(2) * 96'(prod)) >> 32);
               end
            end
            OpF: begin
               unique case (mph_ff)
                  2'd0: acc_ff <= 96'(prod);
                  2'd1: fy_ff  <= 48'(acc_ff + 96'(prod));
                  2'd2: acc_ff <= 96'(prod);
                  default: fz_ff <= 48'(acc_ff + 96'(prod));
               endcase
            end
            OpG: begin
               unique case (mph_ff)
                  2'd0: acc_ff <= 96'(prod);
                  2'd1: gy_ff  <= 48'((acc_ff + 96'(prod) - (96'sd1 <<< 44)
                                       + (96'sd1 <<< 19)) >>> 20);
                  2'd2: acc_ff <= 96'(prod);
                  default: gz_ff <= 48'((acc_ff + 96'(prod) - (96'sd1 <<< 44)
                                         + (96'sd1 <<< 19)) >>> 20);
               endcase
            end
            OpD: begin
               if (mph_ff == 2'd0) begin
                  dy_ff <= sat32(96'(prod) + (96'sd1 <<< 23));
               end else begin
                  dz_ff <= sat32(96'(prod) + (96'sd1 <<< 23));
               end
            end
            default: acc_ff <= acc_ff;
         endcase
      end
      if (div_done) begin
         unique case (ctl.op)
            OpW: w_ff <= 17'(div_q[15:0]);
            OpS: s_ff <= (div_q > 64'd65536) ? 17'd65536 : 17'(div_q);
            OpC: c_ff <= (div_q > 64'd65536) ? 17'd65536 : 17'(div_q);
            default: w_ff <= w_ff;
         endcase
      end
      if (sq_done) begin
         r_ff <= sq_root;
      end
      if (ctl.op == OpR && ctl.sqrt_start) begin
         s_ff <= 17'd0;
         c_ff <= 17'd65536;
      end
      if (ctl.latch_out) begin
         inr_ff    <= hit_ff;
         ifound_ff <= hit_ff ? 4'(found_ff) : 4'd0;
         if (!hit_ff) begin
            dy_ff <= '0;
            dz_ff <= '0;
         end
      end
   end

   assign sts.mul_done = mul_last;

   assign delta_y        = dy_ff;
   assign delta_z        = dz_ff;
   assign in_range       = inr_ff;
   assign interval_found = ifound_ff;
endmodule

>>> rtl/esrs_ctrl.sv
module esrs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               load_we,
   output logic               pt_we,
   input  logic [31:0]        r_value,
   output esrs_pkg::ctl_type  ctl,
   input  esrs_pkg::sts_type  sts
);
   import esrs_pkg::*;

   localparam logic [3:0] StIdle  = 4'd0;
   localparam logic [3:0] StScan  = 4'd1;
   localparam logic [3:0] StW     = 4'd2;
   localparam logic [3:0] StH     = 4'd3;
   localparam logic [3:0] StF     = 4'd4;
   localparam logic [3:0] StR     = 4'd5;
   localparam logic [3:0] StS     = 4'd6;
   localparam logic [3:0] StC     = 4'd7;
   localparam logic [3:0] StG     = 4'd8;
   localparam logic [3:0] StD     = 4'd9;
   localparam logic [3:0] StOut   = 4'd10;
   localparam logic [3:0] StHold  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       go_ff, go_in;
   logic       vld_ff, vld_in;
   logic       accept;

   assign req_stall = (state_ff != StIdle) || (vld_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign load_we   = accept && (req_type == ReqLoad);
   assign pt_we     = accept && (req_type == ReqQuery);
   assign rsp_valid = vld_ff;

   always_comb begin
      state_in = state_ff;
      go_in    = 1'b0;
      vld_in   = vld_ff && rsp_stall;
      ctl      = '0;
      unique case (state_ff)
         StIdle: begin
            ctl.clear_acc = 1'b1;
            if (pt_we) begin
               state_in = StScan;
            end
         end
         StScan: begin
            ctl.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = sts.hit ? StW : StOut;
               go_in    = 1'b1;
            end
         end
         StW: begin
            ctl.op        = OpW;
            ctl.div_start = go_ff;
            if (sts.unit_done) begin
               state_in = StH;
            end
         end
         StH: begin
            ctl.op       = OpH;
            ctl.mul_step = 1'b1;
            if (sts.mul_done) begin
               state_in = StF;
            end
         end
         StF: begin
            ctl.op       = OpF;
            ctl.mul_step = 1'b1;
            if (sts.mul_done) begin
               state_in = StR;
               go_in    = 1'b1;
            end
         end
         StR: begin
            ctl.op         = OpR;
            ctl.sqrt_start = go_ff;
            if (sts.unit_done) begin
               state_in = (r_value == 32'd0) ? StG : StS;
               go_in    = 1'b1;
            end
         end
         StS: begin
            ctl.op        = OpS;
            ctl.div_start = go_ff;
            if (sts.unit_done) begin
               state_in = StC;
               go_in    = 1'b1;
            end
         end
         StC: begin
            ctl.op        = OpC;
            ctl.div_start = go_ff;
            if (sts.unit_done) begin
               state_in = StG;
            end
         end
         StG: begin
            ctl.op       = OpG;
            ctl.mul_step = 1'b1;
            if (sts.mul_done) begin
               state_in = StD;
            end
         end
         StD: begin
            ctl.op       = OpD;
            ctl.mul_step = 1'b1;
            if (sts.mul_done) begin
               state_in = StOut;
            end
         end
         StOut: begin
            ctl.latch_out = 1'b1;
            state_in      = StHold;
         end
         StHold: begin
            if (!(vld_ff && rsp_stall)) begin
               vld_in   = 1'b1;
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         go_ff    <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
         vld_ff   <= vld_in;
      end
   end

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != StIdle) |-> !accept) else $error("item taken while busy");
   a_rsp_after_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(vld_ff) |-> $past(state_ff) == StHold) else $error("stray result");
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      pt_we |=> state_ff == StScan) else $error("query not started");
`endif
endmodule

>>> verif/elliptic_section_radial_scale_core_tb.sv
`timescale 1ns / 100ps

module elliptic_section_radial_scale_core_tb;
   import esrs_pkg::*;

   localparam int NumSections = 16;
   localparam int SettleCycles = 400;
   localparam longint CycleLimit = 4000000;

   typedef struct {
      logic signed [31:0] delta_y;
      logic signed [31:0] delta_z;
      logic in_range;
      logic [3:0] interval_found;
   } disp_type;

   class disp_scoreboard;
      logic signed [31:0] pos_tbl [NumSections];
      logic signed [15:0] fac_tbl [NumSections][3];
      logic [4:0] count;
      disp_type pending[$];
      int errors;

      function new();
         count = 0;
         errors = 0;
      endfunction

      function logic [63:0] int_sqrt(logic [63:0] v);
         logic [63:0] r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function logic signed [31:0] clamp32(logic signed [63:0] v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      function disp_type scale_point(logic signed [31:0] px, logic signed [31:0] py,
                                     logic signed [31:0] pz);
         disp_type d;
         int n, lo;
         logic hit;
         logic signed [63:0] x, y, z, xl, xh, h, fy, fz, s, c, gy, gz;
         logic [63:0] w, w2, w3, ay, az, r;
         int sel;
         d = '{0, 0, 0, 0};
         x = px; y = py; z = pz;
         n = (count > NumSections) ? NumSections : count;
         hit = 0;
         lo = 0;
         for (int i = 0; i + 1 < n; i++)
            if (x >= pos_tbl[i] && x < pos_tbl[i + 1]) begin
               hit = 1;
               lo = i;
            end
         if (!hit) return d;
         xl = pos_tbl[lo];
         xh = pos_tbl[lo + 1];
         w = ((x - xl) << 16) / (xh - xl);
         w2 = w * w;
         w3 = w2 * w;
         h = (3 * (w2 << 16) - 2 * w3) >> 32;
         sel = (y >= 0) ? 0 : 2;
         fy = 64'(fac_tbl[lo][sel]) * (65536 - h) + 64'(fac_tbl[lo + 1][sel]) * h;
         fz = 64'(fac_tbl[lo][1]) * (65536 - h) + 64'(fac_tbl[lo + 1][1]) * h;
         ay = (y < 0) ? -y : y;
         az = (z < 0) ? -z : z;
         r = int_sqrt(ay * ay + az * az);
         if (r == 0) begin
            s = 0;
            c = 65536;
         end else begin
            s = (ay << 16) / r;
            c = (az << 16) / r;
            if (s > 65536) s = 65536;
            if (c > 65536) c = 65536;
         end
         gy = (fy * s + fz * (65536 - s) - (64'sd1 << 44) + (64'sd1 << 19)) >>> 20;
         gz = (fz * c + fy * (65536 - c) - (64'sd1 << 44) + (64'sd1 << 19)) >>> 20;
         d.delta_y = clamp32((y * gy + (64'sd1 << 23)) >>> 24);
         d.delta_z = clamp32((z * gz + (64'sd1 << 23)) >>> 24);
         d.in_range = 1;
         d.interval_found = lo[3:0];
         return d;
      endfunction

      function void note_item(logic typ, logic [3:0] idx, logic signed [31:0] pos,
                              logic signed [15:0] fu, logic signed [15:0] fz,
                              logic signed [15:0] fl, logic signed [31:0] px,
                              logic signed [31:0] py, logic signed [31:0] pz);
         if (typ == ReqLoad) begin
            pos_tbl[idx] = pos;
            fac_tbl[idx][0] = fu;
            fac_tbl[idx][1] = fz;
            fac_tbl[idx][2] = fl;
         end else begin
            pending = {pending, scale_point(px, py, pz)};
         end
      endfunction

      function void check_result(disp_type got);
         disp_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected result dy=%0d dz=%0d", $time, got.delta_y, got.delta_z);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.delta_y !== e.delta_y) begin
            $display("%0t delta_y exp %0d got %0d", $time, e.delta_y, got.delta_y);
            errors++;
         end
         if (got.delta_z !== e.delta_z) begin
            $display("%0t delta_z exp %0d got %0d", $time, e.delta_z, got.delta_z);
            errors++;
         end
         if (got.in_range !== e.in_range) begin
            $display("%0t in_range exp %0d got %0d", $time, e.in_range, got.in_range);
            errors++;
         end
         if (got.interval_found !== e.interval_found) begin
            $display("%0t interval_found exp %0d got %0d", $time, e.interval_found,
                     got.interval_found);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [4:0] csr_wdata = 0;
   logic req_valid = 0;
   logic req_stall;
   logic req_type = 0;
   logic [3:0] req_entry_index = 0;
   logic signed [31:0] req_section_position = 0;
   logic signed [15:0] req_factor_upper_y = 0;
   logic signed [15:0] req_factor_z = 0;
   logic signed [15:0] req_factor_lower_y = 0;
   logic signed [31:0] req_point_x = 0;
   logic signed [31:0] req_point_y = 0;
   logic signed [31:0] req_point_z = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_delta_y;
   logic signed [31:0] rsp_delta_z;
   logic rsp_in_range;
   logic [3:0] rsp_interval_found;

   disp_scoreboard sb = new();
   logic quiet = 0;
   longint cycles = 0;

   elliptic_section_radial_scale_core i_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_entry_index(req_entry_index), .req_section_position(req_section_position),
      .req_factor_upper_y(req_factor_upper_y), .req_factor_z(req_factor_z),
      .req_factor_lower_y(req_factor_lower_y), .req_point_x(req_point_x),
      .req_point_y(req_point_y), .req_point_z(req_point_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_delta_y(rsp_delta_y),
      .rsp_delta_z(rsp_delta_z), .rsp_in_range(rsp_in_range),
      .rsp_interval_found(rsp_interval_found)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_item(req_type, req_entry_index, req_section_position, req_factor_upper_y,
                      req_factor_z, req_factor_lower_y, req_point_x, req_point_y, req_point_z);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_delta_y, rsp_delta_z, rsp_in_range, rsp_interval_found});
   end

   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (quiet) begin
            rsp_stall <= 0;
            @(posedge clock);
         end else begin
            n = $urandom_range(1, 19);
            rsp_stall <= $urandom_range(0, 1);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_item(logic typ, logic [3:0] idx, logic signed [31:0] pos,
                            logic signed [15:0] fu, logic signed [15:0] fz,
                            logic signed [15:0] fl, logic signed [31:0] px,
                            logic signed [31:0] py, logic signed [31:0] pz);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= typ;
      req_entry_index <= idx;
      req_section_position <= pos;
      req_factor_upper_y <= fu;
      req_factor_z <= fz;
      req_factor_lower_y <= fl;
      req_point_x <= px;
      req_point_y <= py;
      req_point_z <= pz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic load_slot(int idx, logic signed [31:0] pos);
      send_item(ReqLoad, idx[3:0], pos, 16'($urandom), 16'($urandom), 16'($urandom),
                $urandom, $urandom, $urandom);
   endtask

   task automatic query(logic signed [31:0] px, logic signed [31:0] py,
                        logic signed [31:0] pz);
      send_item(ReqQuery, 4'($urandom), $urandom, 16'($urandom), 16'($urandom),
                16'($urandom), px, py, pz);
   endtask

   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_count(logic [4:0] v);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      sb.count = v;
   endtask

   // sorted table with random gaps; a few equal neighbors
   task automatic load_table();
      logic signed [63:0] p;
      int sh;
      p = $signed($urandom) >>> $urandom_range(0, 8);
      sh = $urandom_range(4, 27);
      for (int i = 0; i < NumSections; i++) begin
         if (p > 64'sd2147483647) p = 64'sd2147483647;
         load_slot(i, p[31:0]);
         if ($urandom_range(0, 15) != 0) p = p + ({$urandom} >> (31 - sh)) + 1;
      end
   endtask

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 32'sh80000000;
         2: return 32'sh7fffffff;
         3: return $signed($urandom) >>> $urandom_range(0, 30);
         default: return $signed($urandom) >>> $urandom_range(8, 16);
      endcase
   endfunction

   task automatic random_query();
      int n, i;
      logic signed [63:0] lo, hi, px;
      n = (sb.count > NumSections) ? NumSections : sb.count;
      px = $signed($urandom);
      if (n >= 2 && $urandom_range(0, 9) < 8) begin
         i = $urandom_range(0, n - 2);
         lo = sb.pos_tbl[i];
         hi = sb.pos_tbl[i + 1];
         if (hi > lo)
            px = ($urandom_range(0, 7) == 0) ? lo : lo + {$urandom, $urandom} % (hi - lo);
         else
            px = lo;
      end
      query(px[31:0], pick_coord(), pick_coord());
   endtask

   initial begin
      logic [4:0] counts [12];
      counts = '{16, 2, 0, 1, 17, 31, 16, 5, 9, 16, 3, 16};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_count(5'd16);
      send_item(ReqLoad, 4'd0, 32'sh80000000, 16'sh7fff, 16'sh8000, 16'sh7fff, '0, '0, '0);
      send_item(ReqLoad, 4'd1, -32'sd65536000, 16'sh8000, 16'sh7fff, 16'sh8000, '0, '0, '0);
      send_item(ReqLoad, 4'd2, '0, 16'sh1000, 16'sh2000, 16'sh0800, '0, '0, '0);
      send_item(ReqLoad, 4'd3, 32'sd327680, 16'sh3000, 16'sh1000, 16'shf000, '0, '0, '0);
      for (int i = 4; i < NumSections; i++)
         send_item(ReqLoad, i[3:0], 32'sh7fffffff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                   '0, '0, '0);
      query(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
      query(-32'sd1000, 0, 0);
      query(-32'sd1000, 32'sh80000000, 0);
      query(-32'sd1000, 32'sh7fffffff, 0);
      query(100, 32'sd65536, 32'sd65536);
      query(200000, -32'sd70000, 32'sh7fffffff);
      query(32'sh7fffffff, 5, 5);
      query(32'sh7ffffffe, 32'sh80000000, 32'sh80000000);
      query(32'sd327680, 1, -1);

      for (int ph = 0; ph < 12; ph++) begin
         settle();
         if (ph == 11) quiet = 1;
         write_count(counts[ph]);
         load_table();
         for (int k = 0; k < 113; k++) begin
            if (ph == 2 && k == 60) settle();
            if ($urandom_range(0, 9) == 0)
               load_slot($urandom_range(0, 15), $urandom);
            else
               random_query();
         end
      end

      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
